// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/divq_pkg.sv
// Shared types and codes of the deduplicating interrupt vector queue.
package divq_pkg;

    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 3;
    localparam int VEC_W    = 8;
    localparam int STATUS_W = 3;

    // Command codes; any other code behaves as a poll.
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POPPED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_POLLED = 3'd5;

    // Control toward the ring store and its pointers.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               push;
        logic               pop;
        logic [VEC_W-1:0]   vec;
    } t_ring_ctl;

    // Pointer status of the addressed level.
    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_ring_stat;

    // Control toward the presence bit memory.
    typedef struct packed {
        logic [LEVEL_W-1:0] rd_level;
        logic [VEC_W-1:0]   rd_vec;
        logic               wr_en;
        logic [LEVEL_W-1:0] wr_level;
        logic [VEC_W-1:0]   wr_vec;
        logic               wr_bit;
    } t_pres_ctl;

endpackage

// File: rtl/dedup_interrupt_vector_queue.sv
// Top level of the deduplicating interrupt vector queue.
//
// Input channel: i_in_valid with i_cmd, i_level and i_vector; o_in_stall
// holds the sender off. Output channel: o_out_valid with o_status,
// o_vector_out and o_not_empty; i_out_stall holds the result.
// Each transaction yields exactly one result transaction.
// The accept cycle reads the presence bit and the ring slot at the tail;
// in the execute state, once the output register is free, the block then
// decides, writes the ring, presence bit and pointers back, and loads the
// output register. No new transaction is accepted until the last one has
// been decided, because of that read-then-write sequence on the memories.
// After reset the presence memory is swept clear, LEVELS * 256 entries
// (2048 by default); o_in_stall stays high during the sweep. Pointers
// reset to zero at once; ring slots are read only after being written.
// While the receiver stalls, the result holds in the output register and
// one more transaction may be accepted; it finishes once the register frees.
module dedup_interrupt_vector_queue #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [divq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [divq_pkg::LEVEL_W-1:0]    i_level,
    input  logic [divq_pkg::VEC_W-1:0]      i_vector,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [divq_pkg::STATUS_W-1:0]   o_status,
    output logic [divq_pkg::VEC_W-1:0]      o_vector_out,
    output logic                            o_not_empty
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [divq_pkg::CMD_W-1:0]      r_cmd;
    logic [divq_pkg::LEVEL_W-1:0]    r_level;
    logic [divq_pkg::VEC_W-1:0]      r_vector;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [divq_pkg::STATUS_W-1:0]   r_status;
    logic [divq_pkg::STATUS_W-1:0]   n_status;
    logic [divq_pkg::VEC_W-1:0]      r_vout;
    logic [divq_pkg::VEC_W-1:0]      n_vout;
    logic                            r_ne;
    logic                            n_ne;

    logic                            in_accept;
    logic                            out_free;
    logic                            exec_done;
    logic                            lvl_ok;
    logic                            do_push;
    logic                            do_pop;
    logic                            pres_bit;
    logic                            pres_busy;
    logic [divq_pkg::VEC_W-1:0]      ring_vec;
    divq_pkg::t_ring_ctl             ring_ctl;
    divq_pkg::t_ring_stat            ring_stat;
    divq_pkg::t_pres_ctl             pres_ctl;

    // Handshake.
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_done  = (r_state == S_EXEC) && out_free;
    assign o_in_stall = (r_state != S_IDLE);
    assign lvl_ok     = (32'(r_level) < LEVELS);

    // Memory updates happen only in the deciding cycle.
    assign do_push = exec_done && lvl_ok && (r_cmd == divq_pkg::CMD_PUSH)
                     && !pres_bit && !ring_stat.full;
    assign do_pop  = exec_done && lvl_ok && (r_cmd == divq_pkg::CMD_POP)
                     && !ring_stat.empty;

    // Reads are addressed by the incoming transaction while idle.
    always_comb begin
        ring_ctl.level    = (r_state == S_EXEC) ? r_level : i_level;
        ring_ctl.push     = do_push;
        ring_ctl.pop      = do_pop;
        ring_ctl.vec      = r_vector;
        pres_ctl.rd_level = (r_state == S_EXEC) ? r_level : i_level;
        pres_ctl.rd_vec   = (r_state == S_EXEC) ? r_vector : i_vector;
        pres_ctl.wr_en    = do_push || do_pop;
        pres_ctl.wr_level = r_level;
        pres_ctl.wr_vec   = do_push ? r_vector : ring_vec;
        pres_ctl.wr_bit   = do_push;
    end

    divq_ring #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ring_ctl),
        .o_stat   (ring_stat),
        .o_rd_vec (ring_vec)
    );

    divq_presence #(
        .LEVELS (LEVELS)
    ) u_presence (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (pres_ctl),
        .o_rd_bit (pres_bit),
        .o_busy   (pres_busy)
    );

    // Result of the transaction being decided.
    always_comb begin
        n_status = divq_pkg::ST_POLLED;
        n_vout   = '0;
        n_ne     = 1'b0;
        if (!lvl_ok) begin
            unique case (r_cmd)
                divq_pkg::CMD_PUSH: n_status = divq_pkg::ST_FULL;
                divq_pkg::CMD_POP:  n_status = divq_pkg::ST_EMPTY;
                default:            n_status = divq_pkg::ST_POLLED;
            endcase
        end else begin
            unique case (r_cmd)
                divq_pkg::CMD_PUSH: begin
                    if (pres_bit) begin
                        n_status = divq_pkg::ST_DUP;
                        n_ne     = !ring_stat.empty;
                    end else if (ring_stat.full) begin
                        n_status = divq_pkg::ST_FULL;
                        n_ne     = !ring_stat.empty;
                    end else begin
                        n_status = divq_pkg::ST_STORED;
                        n_ne     = 1'b1;
                    end
                end
                divq_pkg::CMD_POP: begin
                    if (ring_stat.empty) begin
                        n_status = divq_pkg::ST_EMPTY;
                    end else begin
                        n_status = divq_pkg::ST_POPPED;
                        n_vout   = ring_vec;
                        n_ne     = !ring_stat.last;
                    end
                end
                default: begin
                    n_status = divq_pkg::ST_POLLED;
                    n_ne     = !ring_stat.empty;
                end
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!pres_busy) n_state = S_IDLE;
            S_IDLE:  if (in_accept) n_state = S_EXEC;
            S_EXEC:  if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    assign n_out_valid = exec_done ? 1'b1 : (r_out_valid && i_out_stall);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Captured transaction and output register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= i_cmd;
            r_level  <= i_level;
            r_vector <= i_vector;
        end
        if (exec_done) begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_ne     <= n_ne;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_vector_out = r_vout;
    assign o_not_empty  = r_ne;

endmodule

// File: rtl/divq_ring.sv
// Ring store memory with per-level head and tail pointers.
module divq_ring #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  divq_pkg::t_ring_ctl          i_ctl,
    output divq_pkg::t_ring_stat         o_stat,
    output logic [divq_pkg::VEC_W-1:0]   o_rd_vec
);

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0]           r_head [LEVELS];
    logic [PTR_W-1:0]           r_tail [LEVELS];
    logic [divq_pkg::VEC_W-1:0] ring_mem [LEVELS][QUEUE_DEPTH];
    logic [divq_pkg::VEC_W-1:0] r_rd_vec;

    logic             lvl_ok;
    logic [LVL_W-1:0] lvl_idx;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_nx;
    logic [PTR_W-1:0] tail_nx;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Select the addressed level; out-of-range levels fall back to level zero.
    assign lvl_ok  = (32'(i_ctl.level) < LEVELS);
    assign lvl_idx = lvl_ok ? LVL_W'(i_ctl.level) : '0;
    assign head    = r_head[lvl_idx];
    assign tail    = r_tail[lvl_idx];
    assign head_nx = ptr_next(head);
    assign tail_nx = ptr_next(tail);

    // Pointer status; one slot always stays unused.
    assign o_stat.empty = (head == tail);
    assign o_stat.full  = (head_nx == tail);
    assign o_stat.last  = (tail_nx == head);

    // Pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            if (i_ctl.push) begin
                r_head[lvl_idx] <= head_nx;
            end
            if (i_ctl.pop) begin
                r_tail[lvl_idx] <= tail_nx;
            end
        end
    end

    // Ring memory: write at the head, registered read at the tail.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            ring_mem[lvl_idx][head] <= i_ctl.vec;
        end
        r_rd_vec <= ring_mem[lvl_idx][tail];
    end

    assign o_rd_vec = r_rd_vec;

endmodule

// File: rtl/divq_presence.sv
// Presence bit memory with a clearing sweep after reset.
module divq_presence #(
    parameter int LEVELS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  divq_pkg::t_pres_ctl i_ctl,
    output logic                o_rd_bit,
    output logic                o_busy
);

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int VSPACE    = 1 << divq_pkg::VEC_W;
    localparam int CNT_W     = LVL_W + divq_pkg::VEC_W;
    localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(LEVELS * VSPACE - 1);

    logic             pres_mem [LEVELS][VSPACE];
    logic             r_rd_bit;
    logic             r_busy;
    logic [CNT_W-1:0] r_clr_cnt;

    logic [LVL_W-1:0] rd_idx;
    logic [LVL_W-1:0] wr_idx;

    // Out-of-range levels fall back to level zero; their results are unused.
    assign rd_idx = (32'(i_ctl.rd_level) < LEVELS) ? LVL_W'(i_ctl.rd_level) : '0;
    assign wr_idx = (32'(i_ctl.wr_level) < LEVELS) ? LVL_W'(i_ctl.wr_level) : '0;

    // Clearing sweep, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            if (r_clr_cnt == CLR_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + CNT_W'(1);
            end
        end
    end

    // Memory: one write port shared by the sweep and updates, one read port.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            pres_mem[r_clr_cnt[CNT_W-1:divq_pkg::VEC_W]][r_clr_cnt[divq_pkg::VEC_W-1:0]] <= 1'b0;
        end else if (i_ctl.wr_en) begin
            pres_mem[wr_idx][i_ctl.wr_vec] <= i_ctl.wr_bit;
        end
        r_rd_bit <= pres_mem[rd_idx][i_ctl.rd_vec];
    end

    assign o_rd_bit = r_rd_bit;
    assign o_busy   = r_busy;

endmodule

// File: rtl/divq_checker.sv
// Port-level checker of the interrupt vector queue and its bind statement.
`include "assert_macros.svh"

module divq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [divq_pkg::STATUS_W-1:0]   o_status,
    input logic [divq_pkg::VEC_W-1:0]      o_vector_out,
    input logic                            o_not_empty
);

    logic                                          in_acc;
    logic                                          out_held;
    logic                                          out_pop;
    logic                                          out_empty;
    logic                                          out_stored;
    logic [divq_pkg::STATUS_W+divq_pkg::VEC_W:0]   out_word;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign out_pop    = o_out_valid && (o_status == divq_pkg::ST_POPPED);
    assign out_empty  = o_out_valid && (o_status == divq_pkg::ST_EMPTY);
    assign out_stored = o_out_valid && (o_status == divq_pkg::ST_STORED);
    assign out_word   = {o_status, o_vector_out, o_not_empty};

    // A held result keeps its contents.
    `CHK_NXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

    // Only a pop transaction carries a vector.
    `CHK_IMP(a_vout_zero, i_clk, i_rst_n, o_out_valid && !out_pop, o_vector_out == '0)

    // An empty pop leaves the queue empty; a stored push leaves it occupied.
    `CHK_IMP(a_empty_flag, i_clk, i_rst_n, out_empty, !o_not_empty)
    `CHK_IMP(a_stored_flag, i_clk, i_rst_n, out_stored, o_not_empty)

    // The block works on one transaction at a time.
    `CHK_NXT(a_one_at_time, i_clk, i_rst_n, in_acc, o_in_stall)

endmodule

bind dedup_interrupt_vector_queue divq_checker u_divq_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the deduplicating interrupt vector queue.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_LEVELS   = 8;
    localparam int RING_DEPTH   = 256;
    localparam int VEC_VALUES   = 256;
    localparam int RESET_CYCLES = 3;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 64;
    localparam int MAX_REPORTS  = 30;
    localparam int DIR_ROWS     = 24;

    // The unused command code, which the block treats as a poll.
    localparam logic [divq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [divq_pkg::STATUS_W-1:0] status;
        logic [divq_pkg::VEC_W-1:0]    vec;
        logic                          ne;
    } t_irq_result;

    // One row of the directed stimulus; typed rows carry their own answer.
    typedef struct packed {
        logic [divq_pkg::CMD_W-1:0]   cmd;
        logic [divq_pkg::LEVEL_W-1:0] level;
        logic [divq_pkg::VEC_W-1:0]   vector;
        logic                         typed;
        t_irq_result                  want;
    } t_stim_row;

    localparam t_irq_result ANY_RESULT = '0;

    // Directed walk over the extremes, every command and the simple special cases.
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        '{divq_pkg::CMD_POP,  3'd0, 8'h00, 1'b1, '{divq_pkg::ST_EMPTY,  8'h00, 1'b0}},
        '{divq_pkg::CMD_POLL, 3'd0, 8'h00, 1'b1, '{divq_pkg::ST_POLLED, 8'h00, 1'b0}},
        '{divq_pkg::CMD_PUSH, 3'd0, 8'h00, 1'b1, '{divq_pkg::ST_STORED, 8'h00, 1'b1}},
        '{divq_pkg::CMD_PUSH, 3'd0, 8'h00, 1'b1, '{divq_pkg::ST_DUP,    8'h00, 1'b1}},
        '{divq_pkg::CMD_PUSH, 3'd0, 8'hFF, 1'b1, '{divq_pkg::ST_STORED, 8'h00, 1'b1}},
        '{divq_pkg::CMD_PUSH, 3'd0, 8'hA5, 1'b0, ANY_RESULT},
        '{CMD_SPARE,          3'd0, 8'hFF, 1'b1, '{divq_pkg::ST_POLLED, 8'h00, 1'b1}},
        '{divq_pkg::CMD_POP,  3'd0, 8'h3C, 1'b1, '{divq_pkg::ST_POPPED, 8'h00, 1'b1}},
        '{divq_pkg::CMD_PUSH, 3'd0, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd0, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_PUSH, 3'd7, 8'hFF, 1'b1, '{divq_pkg::ST_STORED, 8'h00, 1'b1}},
        '{divq_pkg::CMD_PUSH, 3'd7, 8'h5A, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POLL, 3'd7, 8'hA5, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd7, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd7, 8'hFF, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd7, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_PUSH, 3'd3, 8'h80, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_PUSH, 3'd3, 8'h01, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_PUSH, 3'd3, 8'h80, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd3, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd3, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd0, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd0, 8'h00, 1'b0, ANY_RESULT},
        '{divq_pkg::CMD_POP,  3'd0, 8'h00, 1'b0, ANY_RESULT}
    };

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic [divq_pkg::CMD_W-1:0]     i_cmd       = '0;
    logic [divq_pkg::LEVEL_W-1:0]   i_level     = '0;
    logic [divq_pkg::VEC_W-1:0]     i_vector    = '0;
    logic                           i_out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [divq_pkg::STATUS_W-1:0]  o_status;
    logic [divq_pkg::VEC_W-1:0]     o_vector_out;
    logic                           o_not_empty;

    // Shadow copy of the queues: ring slots, presence bits and pointers.
    logic [divq_pkg::VEC_W-1:0] ring_slots [NUM_LEVELS][RING_DEPTH];
    bit                         vec_queued [NUM_LEVELS][VEC_VALUES];
    int unsigned                wr_ptr [NUM_LEVELS];
    int unsigned                rd_ptr [NUM_LEVELS];

    t_irq_result pending_results [$];
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          items_sent      = 0;
    int          status_tally [8];
    int          cycle_count     = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          hold_left       = 0;
    bit          hold_done       = 1'b0;

    dedup_interrupt_vector_queue #(
        .LEVELS      (NUM_LEVELS),
        .QUEUE_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_level      (i_level),
        .i_vector     (i_vector),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_vector_out (o_vector_out),
        .o_not_empty  (o_not_empty)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int unsigned ring_advance(input int unsigned p);
        return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    // Applies one transaction to the shadow queues and returns its result.
    function automatic t_irq_result predict_queue_op(
        input logic [divq_pkg::CMD_W-1:0]   cmd,
        input logic [divq_pkg::LEVEL_W-1:0] lvl,
        input logic [divq_pkg::VEC_W-1:0]   vec
    );
        t_irq_result r;
        int unsigned wp;
        int unsigned rp;
        r.status = divq_pkg::ST_POLLED;
        r.vec    = '0;
        r.ne     = 1'b0;
        // A level without a queue behaves as one that is always empty and full.
        if (int'(lvl) >= NUM_LEVELS) begin
            if (cmd == divq_pkg::CMD_PUSH) begin
                r.status = divq_pkg::ST_FULL;
            end else if (cmd == divq_pkg::CMD_POP) begin
                r.status = divq_pkg::ST_EMPTY;
            end
            return r;
        end
        wp = wr_ptr[lvl];
        rp = rd_ptr[lvl];
        if (cmd == divq_pkg::CMD_PUSH) begin
            if (vec_queued[lvl][vec]) begin
                r.status = divq_pkg::ST_DUP;
            end else if (ring_advance(wp) == rp) begin
                r.status = divq_pkg::ST_FULL;
            end else begin
                ring_slots[lvl][wp]   = vec;
                wr_ptr[lvl]           = ring_advance(wp);
                vec_queued[lvl][vec]  = 1'b1;
                r.status              = divq_pkg::ST_STORED;
            end
        end else if (cmd == divq_pkg::CMD_POP) begin
            if (wp == rp) begin
                r.status = divq_pkg::ST_EMPTY;
            end else begin
                r.vec                  = ring_slots[lvl][rp];
                rd_ptr[lvl]            = ring_advance(rp);
                vec_queued[lvl][r.vec] = 1'b0;
                r.status               = divq_pkg::ST_POPPED;
            end
        end
        r.ne = (wr_ptr[lvl] != rd_ptr[lvl]);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Offers one transaction after a random gap and returns at its accepting edge.
    task automatic send_item(
        input logic [divq_pkg::CMD_W-1:0]   cmd,
        input logic [divq_pkg::LEVEL_W-1:0] lvl,
        input logic [divq_pkg::VEC_W-1:0]   vec,
        input logic                         typed,
        input t_irq_result                  typed_want
    );
        t_irq_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_level    <= lvl;
        i_vector   <= vec;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        want = predict_queue_op(cmd, lvl, vec);
        status_tally[want.status]++;
        pending_results.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    // Random traffic focused on two busy levels and a few vectors, so that
    // duplicates and non-trivial queue depths come up often.
    task automatic send_mixed(input int count);
        int unsigned                  pick;
        logic [divq_pkg::CMD_W-1:0]   cmd;
        logic [divq_pkg::LEVEL_W-1:0] lvl;
        logic [divq_pkg::VEC_W-1:0]   vec;
        logic [divq_pkg::LEVEL_W-1:0] busy_a;
        logic [divq_pkg::LEVEL_W-1:0] busy_b;
        busy_a = divq_pkg::LEVEL_W'($urandom_range(NUM_LEVELS - 1));
        busy_b = divq_pkg::LEVEL_W'($urandom_range(NUM_LEVELS - 1));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            cmd  = (pick < 45) ? divq_pkg::CMD_PUSH : (pick < 80) ? divq_pkg::CMD_POP :
                   (pick < 95) ? divq_pkg::CMD_POLL : CMD_SPARE;
            pick = $urandom_range(99);
            lvl  = (pick < 40) ? busy_a : (pick < 70) ? busy_b :
                   divq_pkg::LEVEL_W'($urandom_range(NUM_LEVELS - 1));
            pick = $urandom_range(99);
            vec  = (pick < 60) ? divq_pkg::VEC_W'($urandom_range(7)) :
                   (pick < 80) ? divq_pkg::VEC_W'(248 + $urandom_range(7)) :
                   divq_pkg::VEC_W'($urandom_range(255));
            send_item(cmd, lvl, vec, 1'b0, ANY_RESULT);
        end
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_irq_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result status %0d with nothing pending", o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", o_status,
                                              want.status));
                end
                if (o_vector_out !== want.vec) begin
                    report_mismatch($sformatf("vector_out %02h, expected %02h",
                                              o_vector_out, want.vec));
                end
                if (o_not_empty !== want.ne) begin
                    report_mismatch($sformatf("not_empty %b, expected %b", o_not_empty,
                                              want.ne));
                end
                results_checked++;
            end
        end
    end

    // Receiver stall generation; one long hold-off is counted down here.
    always @(posedge i_clk) begin
        if (!hold_done && results_checked >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Stimulus sequence: reset, directed table, then three phases with different idle and stall rates.
    initial begin
        logic [divq_pkg::LEVEL_W-1:0] fill_lvl;
        logic [divq_pkg::VEC_W-1:0]   fill_base;
        send_idle_pct  = 17;
        recv_stall_pct = 86;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item(DIR_TABLE[r].cmd, DIR_TABLE[r].level, DIR_TABLE[r].vector,
                      DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end
        send_mixed(450);

        send_idle_pct  = 86;
        recv_stall_pct = 17;
        send_mixed(450);

        // Fill one level until pushes are dropped as full, then drain it past
        // empty; the pointers wrap on the way.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_lvl  = divq_pkg::LEVEL_W'($urandom_range(NUM_LEVELS - 1));
        fill_base = divq_pkg::VEC_W'($urandom_range(255));
        for (int k = 0; k < RING_DEPTH + 4; k++) begin
            send_item(divq_pkg::CMD_PUSH, fill_lvl, fill_base + divq_pkg::VEC_W'(k), 1'b0,
                      ANY_RESULT);
        end
        for (int k = 0; k < RING_DEPTH + 2; k++) begin
            send_item(divq_pkg::CMD_POP, fill_lvl, divq_pkg::VEC_W'($urandom_range(255)),
                      1'b0, ANY_RESULT);
        end
        send_mixed(100);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transactions and %0d checked results.", items_sent,
                 results_checked);
        $display("Outcomes: %0d stored, %0d dup, %0d full, %0d popped, %0d empty, %0d polled.",
                 status_tally[divq_pkg::ST_STORED], status_tally[divq_pkg::ST_DUP],
                 status_tally[divq_pkg::ST_FULL], status_tally[divq_pkg::ST_POPPED],
                 status_tally[divq_pkg::ST_EMPTY], status_tally[divq_pkg::ST_POLLED]);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/divq_pkg.sv
rtl/divq_ring.sv
rtl/divq_presence.sv
rtl/dedup_interrupt_vector_queue.sv
rtl/divq_checker.sv
tb/testbench.sv
